/* hdl/udpck_pkg.sv */
`default_nettype none
package udpck_pkg;

  // Frame position counter width and its saturation value.
  localparam int unsigned PosW = 11;
  localparam logic [PosW-1:0] PosMax = '1;

  // Verdict codes.
  localparam logic [1:0] VERDICT_REDIRECT  = 2'd0;
  localparam logic [1:0] VERDICT_NOT_IPV4  = 2'd1;
  localparam logic [1:0] VERDICT_NOT_UDP   = 2'd2;
  localparam logic [1:0] VERDICT_TRUNCATED = 2'd3;

  // One classified byte, passed from the front end to the accumulator.
  typedef struct packed {
    logic [17:0] addend;   // byte's word part times its summing weight
    logic        last;     // final byte of the frame
    logic [1:0]  verdict;  // meaningful when last is set
    logic [6:0]  offset;   // checksum offset, meaningful when last is set
  } op_t;

  // One finished frame result.
  typedef struct packed {
    logic [1:0]  verdict;
    logic [15:0] checksum;
    logic [6:0]  offset;
    logic [31:0] frames_seen;
    logic [15:0] port;
  } res_t;

endpackage
`default_nettype wire

/* hdl/udpck_front.sv */
`default_nettype none
module udpck_front #(
  parameter int unsigned MAX_UDP_BYTES = 1480
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [7:0]       data_byte,
  input  wire logic             last_byte,
  input  wire logic             q_ready,
  output logic                  in_ready,
  output logic                  push,
  output udpck_pkg::op_t        op
);
  import udpck_pkg::*;

  localparam logic [PosW-1:0] MaxUdp = PosW'(MAX_UDP_BYTES);

  logic [PosW-1:0] pos;
  logic [7:0]      held_high_byte;
  logic [3:0]      hlw;
  logic            is_ipv4;
  logic            is_udp;

  logic [3:0]      hlw_eff;
  logic            ipv4_eff;
  logic            udp_eff;
  logic [PosW-1:0] start;
  logic [PosW-1:0] rel;
  logic            in_udp;
  logic            w_pseudo;
  logic            w_len;
  logic            w_data;
  logic [1:0]      weight;
  logic [15:0]     word_part;
  logic [PosW:0]   len;
  logic [PosW:0]   udp_end;

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;

  always_comb begin
    hlw_eff   = (pos == PosW'(14)) ? data_byte[3:0] : hlw;
    ipv4_eff  = (pos == PosW'(13)) ? (held_high_byte == 8'h08 && data_byte == 8'h00) : is_ipv4;
    udp_eff   = (pos == PosW'(23)) ? (data_byte == 8'd17) : is_udp;
    start     = PosW'(14) + PosW'({hlw_eff, 2'b00});
    rel       = pos - start;
    in_udp    = (pos >= PosW'(14)) && (pos != PosMax) && (pos >= start);
    w_pseudo  = (pos == PosW'(23)) || ((pos >= PosW'(26)) && (pos <= PosW'(33)));
    w_len     = in_udp && ((rel == PosW'(4)) || (rel == PosW'(5)));
    w_data    = in_udp && (rel < MaxUdp) && (rel != PosW'(6)) && (rel != PosW'(7));
    weight    = 2'(w_pseudo) + 2'(w_len) + 2'(w_data);
    word_part = pos[0] ? {8'h00, data_byte} : {data_byte, 8'h00};
    len       = {1'b0, pos} + (PosW+1)'(1);
    udp_end   = {1'b0, start} + (PosW+1)'(8);

    op.addend = 18'(word_part) * 18'(weight);
    op.last   = last_byte;
    op.offset = '0;
    if (len < (PosW+1)'(14)) begin
      op.verdict = VERDICT_TRUNCATED;
    end else if (!ipv4_eff) begin
      op.verdict = VERDICT_NOT_IPV4;
    end else if (len < (PosW+1)'(34)) begin
      op.verdict = VERDICT_TRUNCATED;
    end else if (!udp_eff) begin
      op.verdict = VERDICT_NOT_UDP;
    end else if (len < udp_end) begin
      op.verdict = VERDICT_TRUNCATED;
    end else begin
      op.verdict = VERDICT_REDIRECT;
      op.offset  = 7'(start + PosW'(6));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= '0;
      held_high_byte <= '0;
      hlw            <= '0;
      is_ipv4        <= 1'b0;
      is_udp         <= 1'b0;
    end else if (push) begin
      if (last_byte) begin
        pos            <= '0;
        held_high_byte <= '0;
        hlw            <= '0;
        is_ipv4        <= 1'b0;
        is_udp         <= 1'b0;
      end else begin
        if (pos != PosMax) begin
          pos <= pos + PosW'(1);
        end
        if (pos == PosW'(12)) begin
          held_high_byte <= data_byte;
        end
        hlw     <= hlw_eff;
        is_ipv4 <= ipv4_eff;
        is_udp  <= udp_eff;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/udpck_queue.sv */
`default_nettype none
module udpck_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire udpck_pkg::op_t push_op,
  output logic                ready,
  input  wire logic           pop,
  output logic                valid,
  output udpck_pkg::op_t      head
);
  import udpck_pkg::*;

  op_t        slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign ready = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

/* hdl/udpck_back.sv */
`default_nettype none
module udpck_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           op_valid,
  input  wire udpck_pkg::op_t op,
  output logic                pop,
  input  wire logic [15:0]    redirect_port,
  output logic                res_valid,
  input  wire logic           res_ready,
  output udpck_pkg::res_t     res
);
  import udpck_pkg::*;

  logic [15:0] acc;
  logic [31:0] frame_counter;
  logic [18:0] sum;
  logic [16:0] fold1;
  logic [15:0] folded;

  // End-around carry folded twice brings any weighted add back to 16 bits.
  always_comb begin
    sum    = 19'(acc) + 19'(op.addend);
    fold1  = 17'(sum[15:0]) + 17'(sum[18:16]);
    folded = fold1[15:0] + 16'(fold1[16]);
  end

  assign pop = op_valid && (!op.last || !res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      frame_counter <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (pop) begin
        if (op.last) begin
          acc           <= '0;
          frame_counter <= frame_counter + 32'd1;
        end else begin
          acc <= folded;
        end
      end
      if (pop && op.last) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && op.last) begin
      res.verdict     <= op.verdict;
      res.checksum    <= (op.verdict == VERDICT_REDIRECT) ? ~folded : 16'h0000;
      res.offset      <= op.offset;
      res.frames_seen <= frame_counter + 32'd1;
      res.port        <= redirect_port;
    end
  end

endmodule
`default_nettype wire

/* hdl/udp_ipv4_checksum_rewriter_core.sv */
`default_nettype none
// UDP over IPv4 checksum rewriter.
//
// The input channel (in_valid / in_ready) carries an Ethernet frame one word
// per cycle: each word is one frame byte in wire order, with last_byte set on
// the final byte. The output channel (out_valid / out_ready) carries one word
// per frame: the verdict, the recomputed UDP checksum and the frame offset of
// its high byte, the running frame count and a copy of the redirect port.
// The redirect port is written through cfg_write_en / cfg_write_data.
//
// A byte is classified by the front end in the cycle it is accepted and goes
// into a two-entry queue; the accumulator drains the queue at one word per
// cycle, but stops at a final byte while the previous result is not taken.
// out_valid rises when the accumulator pops a frame's final byte and
// registers the result. One byte per cycle is sustained while results
// are taken, limited by the single ones' complement add in the accumulator.
//
// Reset clears the frame state, the frame counter, the redirect port and the
// queue. When the receiver stalls, the result is held in the output register;
// the accumulator stops at the next final byte, the queue fills and in_ready
// falls until the result is taken.
module udp_ipv4_checksum_rewriter_core #(
  parameter int unsigned MAX_UDP_BYTES = 1480
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       verdict,
  output logic [15:0]      checksum,
  output logic [6:0]       checksum_offset,
  output logic [31:0]      frames_seen,
  output logic [15:0]      port_out,
  input  wire logic        cfg_write_en,
  input  wire logic [15:0] cfg_write_data
);
  import udpck_pkg::*;

  logic [15:0] redirect_port;
  logic        q_ready;
  logic        push;
  op_t         push_op;
  logic        q_valid;
  op_t         q_head;
  logic        pop;
  res_t        res;

  // The user must rewrite the port only while no frame is in flight; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      redirect_port <= '0;
    end else if (cfg_write_en) begin
      redirect_port <= cfg_write_data;
    end
  end

  udpck_front #(
    .MAX_UDP_BYTES(MAX_UDP_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .q_ready  (q_ready),
    .in_ready (in_ready),
    .push     (push),
    .op       (push_op)
  );

  udpck_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_op(push_op),
    .ready  (q_ready),
    .pop    (pop),
    .valid  (q_valid),
    .head   (q_head)
  );

  udpck_back u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (q_valid),
    .op           (q_head),
    .pop          (pop),
    .redirect_port(redirect_port),
    .res_valid    (out_valid),
    .res_ready    (out_ready),
    .res          (res)
  );

  assign verdict         = res.verdict;
  assign checksum        = res.checksum;
  assign checksum_offset = res.offset;
  assign frames_seen     = res.frames_seen;
  assign port_out        = res.port;

`ifndef SYNTHESIS
  // Successive results carry consecutive frame counts.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=>
      (!out_valid || frames_seen == $past(frames_seen) + 32'd1))
    else $error("frame count did not advance by one between results");

  // A rejected frame reports neither checksum nor offset.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && verdict != VERDICT_REDIRECT) |->
      (checksum == 16'h0000 && checksum_offset == 7'd0))
    else $error("rejected frame carries a checksum or offset");

  // The checksum field always lies beyond the Ethernet header.
  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && verdict == VERDICT_REDIRECT) |-> (checksum_offset >= 7'd20))
    else $error("checksum offset inside the Ethernet header");
`endif

endmodule
`default_nettype wire
